// ===== sv/baro_temp_pressure_compensation_assert.svh =====
// Assertion macros for the compensation block.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`ifndef SYNTHESIS
`define BTPC_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BTPC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define BTPC_ASSERT_IMPL(label, clk, rst_n, a, c)
`define BTPC_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== sv/btpc_pkg.sv =====
`default_nettype none
package btpc_pkg;
    localparam logic [1:0] RegTemp = 2'd0;
    localparam logic [1:0] RegPa = 2'd1;
    localparam logic [1:0] RegPb = 2'd2;
    localparam logic [1:0] RegPc = 2'd3;
    localparam logic [0:0] OpTemp = 1'b0;
    localparam logic [0:0] OpPress = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_OUT
    } t_seq_state;

    // sign-extend a 16-bit field
    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] s);
        return $unsigned($signed(x) >>> s);
    endfunction
endpackage
`default_nettype wire

// ===== sv/btpc_mul.sv =====
`default_nettype none
// Bit-serial 32x32 multiplier, low 32 bits of the product, one bit a cycle.
module btpc_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_done,
    output logic [31:0]      o_p
);
    import btpc_pkg::*;
    logic [31:0] r_acc, r_a, r_b;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                if (r_b[0]) r_acc <= r_acc + r_a;
                r_a   <= {r_a[30:0], 1'b0};
                r_b   <= {1'b0, r_b[31:1]};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_p = r_acc;
endmodule
`default_nettype wire

// ===== sv/btpc_div.sv =====
`default_nettype none
// Restoring unsigned 32/32 divider, one quotient bit a cycle.
module btpc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_n,
    input  wire logic [31:0] i_d,
    output logic             o_done,
    output logic [31:0]      o_q
);
    import btpc_pkg::*;
    logic [31:0] r_q, r_d, r_r;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] w_sh, w_diff;

    assign w_sh = {r_r, r_q[31]};
    assign w_diff = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_q    <= i_n;
                r_d    <= i_d;
                r_r    <= '0;
            end else if (r_busy) begin
                if (!w_diff[32]) begin
                    r_r <= w_diff[31:0];
                    r_q <= {r_q[30:0], 1'b1};
                end else begin
                    r_r <= w_sh[31:0];
                    r_q <= {r_q[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_q = r_q;
endmodule
`default_nettype wire

// ===== sv/baro_temp_pressure_compensation.sv =====
`default_nettype none
// Temperature takes four serial products; pressure takes ten products and one
// quotient, or stops after six products when the divisor is zero. Each product
// or quotient goes through issue, start, one step per operand bit, and done.
// Throughput: one item at a time; the next item is taken the cycle after the result
// has left the output register. Reset (synchronous, active low) clears the sequencer
// state, coefficients and output valid; scratch and result registers are not reset.
module baro_temp_pressure_compensation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // [19:0] raw_reading
    input  wire logic        s_axis_tuser,  // [0] operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // [31:0] temperature_centi, [63:32] pressure_pa,
                                            // [64] zero_divisor
    output logic             m_axis_tuser,  // [0] result_kind
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data
);
    import btpc_pkg::*;
`include "baro_temp_pressure_compensation_assert.svh"

    logic [47:0] r_tc, r_pa, r_pb, r_pc;
    logic [31:0] r_fine;
    t_seq_state  r_state, n_state;
    logic [4:0]  r_step, n_step;       // micro-op counter
    logic        r_op;
    logic [31:0] r_raw;
    // scratch registers
    logic [31:0] r_x0, r_x1, r_x2, r_x3, r_x4;
    logic [31:0] n_x0, n_x1, n_x2, n_x3, n_x4, n_fine;
    logic [31:0] r_res, n_res;
    logic        r_zero, n_zero, r_ovalid, n_ovalid;
    logic        w_mstart, w_dstart, w_mdone, w_ddone;
    logic [31:0] w_ma, w_mb, w_mp, w_dn, w_dd, w_dq;
    logic        n_mstart, n_dstart;
    logic        r_mstart, r_dstart;
    logic [31:0] n_ma, n_mb, r_ma, r_mb, n_dn, n_dd, r_dn, r_dd;

    // coefficients
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, r_tc[15:0]};
    assign t2 = sx16(r_tc[31:16]);
    assign t3 = sx16(r_tc[47:32]);
    assign p1 = {16'd0, r_pa[15:0]};
    assign p2 = sx16(r_pa[31:16]);
    assign p3 = sx16(r_pa[47:32]);
    assign p4 = sx16(r_pb[15:0]);
    assign p5 = sx16(r_pb[31:16]);
    assign p6 = sx16(r_pb[47:32]);
    assign p7 = sx16(r_pc[15:0]);
    assign p8 = sx16(r_pc[31:16]);
    assign p9 = sx16(r_pc[47:32]);

    assign w_mstart = r_mstart;
    assign w_dstart = r_dstart;
    assign w_ma = r_ma;
    assign w_mb = r_mb;
    assign w_dn = r_dn;
    assign w_dd = r_dd;

    btpc_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart),
        .i_a(w_ma), .i_b(w_mb), .o_done(w_mdone), .o_p(w_mp));
    btpc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_n(w_dn), .i_d(w_dd), .o_done(w_ddone), .o_q(w_dq));

    assign o_cfg_ready = (r_state == S_IDLE);
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser = r_op;
    assign m_axis_tdata = {7'd0, r_zero,
                           (r_op ? r_res : 32'd0), (r_op ? 32'd0 : r_res)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= '0;
            r_tc <= '0; r_pa <= '0; r_pb <= '0; r_pc <= '0;
            r_fine <= '0;
            r_ovalid <= 1'b0;
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    RegTemp: r_tc <= i_cfg_data;
                    RegPa:   r_pa <= i_cfg_data;
                    RegPb:   r_pb <= i_cfg_data;
                    RegPc:   r_pc <= i_cfg_data;
                    default: r_tc <= r_tc;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_op <= s_axis_tuser;
                r_raw <= {12'd0, s_axis_tdata[19:0]};
            end
            r_state <= n_state;
            r_step <= n_step;
            r_fine <= n_fine;
            r_ovalid <= n_ovalid;
            r_mstart <= n_mstart;
            r_dstart <= n_dstart;
        end
        r_x0 <= n_x0; r_x1 <= n_x1; r_x2 <= n_x2; r_x3 <= n_x3; r_x4 <= n_x4;
        r_res <= n_res; r_zero <= n_zero;
        r_ma <= n_ma; r_mb <= n_mb; r_dn <= n_dn; r_dd <= n_dd;
    end

    // Sequencer: each step issues one multiply or divide and, on completion, folds
    // the result into scratch registers, or into the result register at the end.
    always_comb begin
        n_state = r_state; n_step = r_step;
        n_x0 = r_x0; n_x1 = r_x1; n_x2 = r_x2; n_x3 = r_x3; n_x4 = r_x4;
        n_fine = r_fine; n_res = r_res; n_zero = r_zero;
        n_ovalid = r_ovalid;
        n_mstart = 1'b0; n_dstart = 1'b0;
        n_ma = r_ma; n_mb = r_mb; n_dn = r_dn; n_dd = r_dd;
        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_state = S_ISSUE;
                    n_step = '0;
                end
            end
            S_ISSUE: begin
                n_state = S_WAIT;
                if (r_op == OpTemp) begin
                    case (r_step)
                        5'd0: begin n_ma = asr32(r_raw, 5'd3) - (t1 << 1); n_mb = t2; end
                        5'd1: begin
                            n_x0 = asr32(r_raw, 5'd4) - t1;
                            n_ma = asr32(r_raw, 5'd4) - t1;
                            n_mb = asr32(r_raw, 5'd4) - t1;
                        end
                        5'd2: begin n_ma = asr32(r_x1, 5'd12); n_mb = t3; end
                        5'd3: begin n_ma = r_fine; n_mb = 32'd5; end
                        default: begin n_ma = '0; n_mb = '0; end
                    endcase
                    n_mstart = 1'b1;
                end else begin
                    case (r_step)
                        5'd0: begin
                            n_x0 = asr32(r_fine, 5'd1) - 32'd64000;
                            n_ma = asr32(asr32(r_fine, 5'd1) - 32'd64000, 5'd2);
                            n_mb = asr32(asr32(r_fine, 5'd1) - 32'd64000, 5'd2);
                            n_mstart = 1'b1;
                        end
                        5'd1: begin n_ma = asr32(r_x1, 5'd11); n_mb = p6; n_mstart = 1'b1; end
                        5'd2: begin n_ma = r_x0; n_mb = p5; n_mstart = 1'b1; end
                        5'd3: begin n_ma = p3; n_mb = asr32(r_x1, 5'd13); n_mstart = 1'b1; end
                        5'd4: begin n_ma = p2; n_mb = r_x0; n_mstart = 1'b1; end
                        5'd5: begin n_ma = 32'd32768 + r_x3; n_mb = p1; n_mstart = 1'b1; end
                        5'd6: begin
                            n_ma = (32'd1048576 - r_raw) - asr32(r_x2, 5'd12);
                            n_mb = 32'd3125; n_mstart = 1'b1;
                        end
                        5'd7: begin
                            n_dn = r_x4[31] ? r_x4 : (r_x4 << 1);
                            n_dd = r_x3; n_dstart = 1'b1;
                        end
                        5'd8: begin n_ma = r_x4 >> 3; n_mb = r_x4 >> 3; n_mstart = 1'b1; end
                        5'd9: begin n_ma = p9; n_mb = r_x1 >> 13; n_mstart = 1'b1; end
                        5'd10: begin n_ma = r_x4 >> 2; n_mb = p8; n_mstart = 1'b1; end
                        default: begin n_mstart = 1'b1; end
                    endcase
                end
            end
            S_WAIT: begin
                if (w_mdone || w_ddone) begin
                    n_state = S_ISSUE;
                    n_step = r_step + 5'd1;
                    if (r_op == OpTemp) begin
                        case (r_step)
                            5'd0: n_x2 = asr32(w_mp, 5'd11);
                            5'd1: n_x1 = w_mp;
                            5'd2: n_fine = r_x2 + asr32(w_mp, 5'd14);
                            default: begin
                                n_res = asr32(w_mp + 32'd128, 5'd8);
                                n_zero = 1'b0;
                                n_state = S_OUT;
                            end
                        endcase
                    end else begin
                        case (r_step)
                            5'd0: n_x1 = w_mp;                       // sq
                            5'd1: n_x2 = w_mp;                       // (sq>>11)*p6
                            5'd2: n_x2 = asr32(r_x2 + (w_mp << 1), 5'd2) + (p4 << 16);
                            5'd3: n_x3 = asr32(w_mp, 5'd3);
                            5'd4: n_x3 = asr32(r_x3 + asr32(w_mp, 5'd1), 5'd18);
                            5'd5: begin
                                n_x3 = asr32(w_mp, 5'd15);
                                if (asr32(w_mp, 5'd15) == 32'd0) begin
                                    n_res = '0; n_zero = 1'b1; n_state = S_OUT;
                                end
                            end
                            5'd6: n_x4 = w_mp;
                            5'd7: n_x4 = r_x4[31] ? (w_dq << 1) : w_dq;
                            5'd8: n_x1 = w_mp;                       // x
                            5'd9: n_x2 = asr32(w_mp, 5'd12);         // w1
                            default: begin
                                n_res = r_x4 + asr32(r_x2 + asr32(w_mp, 5'd13) + p7, 5'd4);
                                n_zero = 1'b0;
                                n_state = S_OUT;
                            end
                        endcase
                    end
                end
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    `BTPC_ASSERT_IMPL(a_out_kind_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser,
        !m_axis_tdata[64])
    `BTPC_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready)
    `BTPC_ASSERT_NEXT(a_out_after, i_clk, i_rst_n, r_state == S_OUT, m_axis_tvalid)
endmodule
`default_nettype wire

// ===== sim/baro_comp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module baro_comp_checker
    import btpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [23:0] i_in_data,
    input  wire logic        i_in_user,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [71:0] i_out_data,
    input  wire logic        i_out_user,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic        kind;
        logic [31:0] temp_centi;
        logic [31:0] press_pa;
        logic        zero_div;
    } t_reading;

    logic [47:0] coef_t, coef_pa, coef_pb, coef_pc;
    logic [31:0] t_fine;
    t_reading    readings_due[$];

    function automatic logic [31:0] sra(input logic [31:0] x, input int s);
        return $unsigned($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] sfld(input logic [47:0] r, input int pos);
        logic [15:0] v;
        v = r[pos +: 16];
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] compensate_temp(input logic [31:0] raw);
        logic [31:0] t1, t2, t3, a, d, b;
        t1 = {16'd0, coef_t[15:0]};
        t2 = sfld(coef_t, 16);
        t3 = sfld(coef_t, 32);
        a = sra((sra(raw, 3) - (t1 << 1)) * t2, 11);
        d = sra(raw, 4) - t1;
        b = sra(sra(d * d, 12) * t3, 14);
        t_fine = a + b;
        return sra(t_fine * 32'd5 + 32'd128, 8);
    endfunction

    function automatic logic [31:0] compensate_press(input logic [31:0] raw,
                                                     output logic zero);
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] v1, sq, v2, p, x, w1, w2;
        p1 = {16'd0, coef_pa[15:0]};
        p2 = sfld(coef_pa, 16);
        p3 = sfld(coef_pa, 32);
        p4 = sfld(coef_pb, 0);
        p5 = sfld(coef_pb, 16);
        p6 = sfld(coef_pb, 32);
        p7 = sfld(coef_pc, 0);
        p8 = sfld(coef_pc, 16);
        p9 = sfld(coef_pc, 32);
        v1 = sra(t_fine, 1) - 32'd64000;
        sq = sra(v1, 2) * sra(v1, 2);
        v2 = sra(sq, 11) * p6 + ((v1 * p5) << 1);
        v2 = sra(v2, 2) + (p4 << 16);
        v1 = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * v1, 1), 18);
        v1 = sra((32'd32768 + v1) * p1, 15);
        if (v1 == 32'd0) begin
            zero = 1'b1;
            return 32'd0;
        end
        zero = 1'b0;
        p = ((32'd1048576 - raw) - sra(v2, 12)) * 32'd3125;
        if (p < 32'h8000_0000) p = (p << 1) / v1;
        else p = (p / v1) << 1;
        x = (p >> 3) * (p >> 3);
        w1 = sra(p9 * (x >> 13), 12);
        w2 = sra((p >> 2) * p8, 13);
        return p + sra(w1 + w2 + p7, 4);
    endfunction

    assign o_pending = readings_due.size();

    always @(posedge i_clk) begin
        t_reading want, got;
        logic     z;
        if (!i_rst_n) begin
            coef_t <= '0; coef_pa <= '0; coef_pb <= '0; coef_pc <= '0;
            t_fine = '0;
            o_fail_count <= 0;
            readings_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    RegTemp: coef_t <= i_cfg_data;
                    RegPa:   coef_pa <= i_cfg_data;
                    RegPb:   coef_pb <= i_cfg_data;
                    default: coef_pc <= i_cfg_data;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                want = '0;
                if (i_in_user == OpTemp) begin
                    want.temp_centi = compensate_temp({12'd0, i_in_data[19:0]});
                end else begin
                    want.kind = 1'b1;
                    want.press_pa = compensate_press({12'd0, i_in_data[19:0]}, z);
                    want.zero_div = z;
                end
                readings_due.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got.kind = i_out_user;
                got.temp_centi = i_out_data[31:0];
                got.press_pa = i_out_data[63:32];
                got.zero_div = i_out_data[64];
                if (readings_due.size() == 0) begin
                    $error("unexpected result kind=%0d", got.kind);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = readings_due.pop_front();
                    if (got != want) o_fail_count <= o_fail_count + 1;
                    if (got.kind != want.kind)
                        $error("result_kind exp %0d got %0d", want.kind, got.kind);
                    if (got.temp_centi != want.temp_centi)
                        $error("temperature_centi exp %0d got %0d",
                               $signed(want.temp_centi), $signed(got.temp_centi));
                    if (got.press_pa != want.press_pa)
                        $error("pressure_pa exp %0d got %0d", want.press_pa, got.press_pa);
                    if (got.zero_div != want.zero_div)
                        $error("zero_divisor exp %0d got %0d", want.zero_div, got.zero_div);
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== sim/tb_baro_temp_pressure_compensation.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_baro_temp_pressure_compensation;
    import btpc_pkg::*;

    localparam int StallLimit = 20000;  // idle cycles before giving up

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // [19:0] raw_reading
    logic        s_axis_tuser = 1'b0;  // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;  // [31:0] temp, [63:32] pressure, [64] zero_divisor
    logic        m_axis_tuser;  // [0] result_kind
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;

    int fail_count, pending;
    int send_idle_pct, recv_idle_pct;
    int quiet_cycles;

    always #5 i_clk = ~i_clk;

    baro_temp_pressure_compensation uut (.*);

    baro_comp_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // receiver: random back-pressure at the current rate
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every outstanding result, plus slack for the pipeline
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic send_reading(input logic op, input logic [19:0] raw);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'd0, raw};
        do @(posedge i_clk); while (!s_axis_tready);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [47:0] rnd48();
        return {16'($urandom_range(16'hFFFF)), $urandom()};
    endfunction

    // plausible calibration set with random jitter in most coefficients
    task automatic load_typical();
        write_reg(RegTemp, {16'($signed(50) + $urandom_range(40)),
                            16'(26000 + $urandom_range(1000)),
                            16'(27000 + $urandom_range(2000))});
        write_reg(RegPa, {16'($signed(3024)), 16'(-16'sd10700 + $urandom_range(100)),
                          16'(36000 + $urandom_range(2000))});
        write_reg(RegPb, {16'(-16'sd7), 16'(140 + $urandom_range(10)),
                          16'(2800 + $urandom_range(200))});
        write_reg(RegPc, {16'(6000), 16'(-16'sd7), 16'($urandom_range(16'hFFFF) % 16 + 15500)});
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            // mostly temperature then pressure pairs, with some lone items
            if ($urandom_range(3) != 0) begin
                send_reading(OpTemp, 20'(400000 + $urandom_range(200000)));
                send_reading(OpPress, 20'(250000 + $urandom_range(200000)));
                i++;
            end else begin
                send_reading(1'($urandom_range(1)), 20'($urandom()));
            end
        end
    endtask

    initial begin
        send_idle_pct = 30;
        recv_idle_pct = 60;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset coefficients, pressure before any temperature (zero divisor)
        send_reading(OpPress, 20'd0);
        send_reading(OpTemp, 20'hFFFFF);
        send_reading(OpPress, 20'hFFFFF);
        drain();
        // all-ones and extreme-sign coefficients, wrap-around everywhere
        write_reg(RegTemp, 48'hFFFF_FFFF_FFFF);
        write_reg(RegPa, 48'hFFFF_FFFF_FFFF);
        write_reg(RegPb, 48'h8000_8000_8000);
        write_reg(RegPc, 48'h7FFF_7FFF_7FFF);
        send_reading(OpTemp, 20'd0);
        send_reading(OpPress, 20'd0);
        send_reading(OpTemp, 20'hFFFFF);
        send_reading(OpPress, 20'hFFFFF);
        send_reading(OpTemp, 20'h55555);
        send_reading(OpPress, 20'hAAAAA);
        drain();
        write_reg(RegTemp, 48'h8000_8000_0000);
        write_reg(RegPa, 48'h7FFF_7FFF_0001);
        send_reading(OpTemp, 20'h80000);
        send_reading(OpPress, 20'h00001);
        send_reading(OpPress, 20'h7FFFF);
        drain();
        load_typical();
        send_reading(OpTemp, 20'd519888);
        send_reading(OpPress, 20'd415148);
        send_reading(OpPress, 20'd0);
        send_reading(OpPress, 20'hFFFFF);
        // hold off until the block has caught up completely
        while (pending != 0) @(posedge i_clk);
        send_reading(OpTemp, 20'd1);

        random_phase(500);
        drain();
        write_reg(RegTemp, rnd48());
        write_reg(RegPa, rnd48());
        write_reg(RegPb, rnd48());
        write_reg(RegPc, rnd48());
        random_phase(100);

        send_idle_pct = 60;
        recv_idle_pct = 30;
        drain();
        load_typical();
        random_phase(450);
        drain();
        write_reg(RegPa, {32'($urandom()), 16'd0});  // p1 = 0 forces zero divisor
        random_phase(60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        drain();
        load_typical();
        random_phase(500);
        drain();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
